FILE: sv/tedt_pkg.sv
package tedt_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_W = 16;
	localparam int TIME_W = 32;
	localparam int TYPE_W = 16;
	localparam int CODE_W = 16;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_END   = 2'd1,
		KIND_MOVE  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GLITCH_WIN = 2'd0,
		CFG_DTAP_WIN   = 2'd1,
		CFG_BACKLIGHT  = 2'd2
	} cfg_idx_t;

	localparam logic [TYPE_W-1:0] EV_TYPE_SYNC = 16'd0;
	localparam logic [TYPE_W-1:0] EV_TYPE_KEY  = 16'd1;
	localparam logic [TYPE_W-1:0] EV_TYPE_ABS  = 16'd3;
	localparam logic [CODE_W-1:0] TOUCH_KEY_CODE = 16'd330;
	localparam logic [CODE_W-1:0] AXIS_X = 16'd0;
	localparam logic [CODE_W-1:0] AXIS_Y = 16'd1;

	localparam logic [WIN_W-1:0] GLITCH_WIN_RST = 16'd20;
	localparam logic [WIN_W-1:0] DTAP_WIN_RST   = 16'd500;

endpackage

FILE: sv/touch_event_decoder_double_tap.sv
// touch event decoder with double-tap detection
// input channel: in_valid / in_stall with event_type, event_code, event_value
// and time_ms; a transfer happens on a rising edge with in_valid high and
// in_stall low. events go into an input register and are decoded from there
// against the held gesture state.
// output channel: out_valid / out_stall with gesture_kind, pos_x, pos_y,
// double_tap and acknowledged. only a sync event gives a result.
// a sync event passes from the input register into the result register.
// throughput: one event per cycle; the decode is a handful of compares and
// one 33-bit add per window check between the input and result registers.
// when the receiver stalls, the result register holds; a further sync in
// the input register waits, and in_stall rises until the result is taken.
// key and axis events still drain while the output is stalled.
// configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// index 0 glitch window, 1 double-tap window, 2 backlight enable.
// reset (arst_n low) empties both registers and restores windows 20 and
// 500 ms, backlight on, pending kind move, coordinates and times zero.
module touch_event_decoder_double_tap #(
	parameter int COORD_BITS = tedt_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tedt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tedt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [tedt_pkg::TYPE_W-1:0]          event_type,
	input  logic [tedt_pkg::CODE_W-1:0]          event_code,
	input  logic signed [tedt_pkg::VALUE_W-1:0]  event_value,
	input  logic [tedt_pkg::TIME_W-1:0]          time_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           gesture_kind,
	output logic [COORD_BITS-1:0]                pos_x,
	output logic [COORD_BITS-1:0]                pos_y,
	output logic                                 double_tap,
	output logic                                 acknowledged
);

	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

	logic [tedt_pkg::WIN_W-1:0] glitch_win_q;
	logic [tedt_pkg::WIN_W-1:0] dtap_win_q;
	logic                       backlight_q;

	logic                             valid_s1;
	logic [tedt_pkg::TYPE_W-1:0]      type_s1;
	logic [tedt_pkg::CODE_W-1:0]      code_s1;
	logic [tedt_pkg::VALUE_W-1:0]     value_s1;
	logic [tedt_pkg::TIME_W-1:0]      time_s1;

	tedt_pkg::kind_t              pending_q;
	logic [COORD_BITS-1:0]        held_x_q;
	logic [COORD_BITS-1:0]        held_y_q;
	logic [tedt_pkg::TIME_W-1:0]  last_start_q;
	logic [tedt_pkg::TIME_W-1:0]  first_tap_q;
	logic                         ack_q;

	logic                         out_valid_q;
	tedt_pkg::kind_t              kind_q;
	logic [COORD_BITS-1:0]        pos_x_q;
	logic [COORD_BITS-1:0]        pos_y_q;
	logic                         dtap_q;
	logic                         ack_out_q;

	logic                         is_sync;
	logic                         out_free;
	logic                         advance;
	logic                         fire;
	logic [tedt_pkg::TIME_W:0]    glitch_end;
	logic [tedt_pkg::TIME_W:0]    dtap_end;
	logic                         not_glitch;
	logic                         in_dtap;
	logic                         start_ok;
	logic                         is_dtap;
	logic [COORD_BITS-1:0]        coord_sat;
	logic                         axis_ok;

	assign is_sync    = (type_s1 == tedt_pkg::EV_TYPE_SYNC);
	assign out_free   = !out_valid_q || !out_stall;
	assign advance    = !valid_s1 || !is_sync || out_free;
	assign fire       = valid_s1 && advance;
	assign in_stall   = !advance;

	assign glitch_end = {1'b0, last_start_q} + {17'd0, glitch_win_q};
	assign dtap_end   = {1'b0, first_tap_q} + {17'd0, dtap_win_q};
	assign not_glitch = {1'b0, time_s1} >= glitch_end;
	assign in_dtap    = {1'b0, time_s1} < dtap_end;
	assign start_ok   = (pending_q == tedt_pkg::KIND_START) && not_glitch;
	assign is_dtap    = start_ok && backlight_q && in_dtap;

	assign axis_ok   = !value_s1[tedt_pkg::VALUE_W-1] && (value_s1 != '0);
	assign coord_sat = (value_s1[tedt_pkg::VALUE_W-1:COORD_BITS] != '0)
		? COORD_MAX : value_s1[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_win_q <= tedt_pkg::GLITCH_WIN_RST;
			dtap_win_q   <= tedt_pkg::DTAP_WIN_RST;
			backlight_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tedt_pkg::CFG_GLITCH_WIN: glitch_win_q <= cfg_data;
				tedt_pkg::CFG_DTAP_WIN:   dtap_win_q   <= cfg_data;
				tedt_pkg::CFG_BACKLIGHT:  backlight_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			type_s1  <= event_type;
			code_s1  <= event_code;
			value_s1 <= event_value;
			time_s1  <= time_ms;
		end
	end

	// gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= tedt_pkg::KIND_MOVE;
			held_x_q     <= '0;
			held_y_q     <= '0;
			last_start_q <= '0;
			first_tap_q  <= '0;
			ack_q        <= 1'b0;
		end else if (fire) begin
			if (is_sync) begin
				pending_q <= tedt_pkg::KIND_MOVE;
				if (start_ok) begin
					last_start_q <= time_s1;
					if (backlight_q && !in_dtap) begin
						first_tap_q <= time_s1;
					end
				end
				if (is_dtap) begin
					ack_q <= 1'b1;
				end
			end else if (type_s1 == tedt_pkg::EV_TYPE_KEY
					&& code_s1 == tedt_pkg::TOUCH_KEY_CODE) begin
				if (value_s1 == 32'd1) begin
					pending_q <= tedt_pkg::KIND_START;
				end else if (value_s1 == '0) begin
					pending_q <= tedt_pkg::KIND_END;
				end
			end else if (type_s1 == tedt_pkg::EV_TYPE_ABS && axis_ok) begin
				if (code_s1 == tedt_pkg::AXIS_X) begin
					held_x_q <= coord_sat;
				end else if (code_s1 == tedt_pkg::AXIS_Y) begin
					held_y_q <= coord_sat;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_sync) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_sync) begin
			kind_q    <= pending_q;
			dtap_q    <= is_dtap;
			ack_out_q <= ack_q || is_dtap;
			if (pending_q == tedt_pkg::KIND_END) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
			end else begin
				pos_x_q <= held_x_q;
				pos_y_q <= held_y_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign gesture_kind = kind_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign double_tap   = dtap_q;
	assign acknowledged = ack_out_q;

endmodule
